// ----- src/i2da_pkg.sv -----
// Shared constants and types for the integer to decimal ASCII core.
`default_nettype none
package i2da_pkg;

    localparam int VALUE_BITS = 64;
    // Decimal digits needed for 2^VALUE_BITS - 1 (log10(2) ~ 0.30103)
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_CLEAR  = 2'd1,
        CELL_DABBLE = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage
`default_nettype wire

// ----- src/i2da_cell.sv -----
// One BCD digit cell of the shift-add-3 chain; also shifts digits upward for output.
`default_nettype none
module i2da_cell (
    input  wire                 aclk,
    input  i2da_pkg::cell_mode_t mode,
    input  wire                 bit_in,
    input  wire  [3:0]          digit_in,
    output logic                bit_out,
    output logic [3:0]          digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 before the shift when the digit would overflow past 9
    assign adj     = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign bit_out = adj[3];
    assign digit_out = digit_reg;

    always_comb begin
        unique case (mode)
            i2da_pkg::CELL_CLEAR:  digit_next = 4'd0;
            i2da_pkg::CELL_DABBLE: digit_next = {adj[2:0], bit_in};
            i2da_pkg::CELL_SHIFT:  digit_next = digit_in;
            default:               digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule
`default_nettype wire

// ----- src/integer_to_decimal_ascii_core.sv -----
// Top level: converts a signed or unsigned integer to decimal ASCII text, one character per beat.
//
//  Channel | Dir | Payload
//  s_      | in  | tdata[63:0] = value, tuser[0] = kind (1 = signed)
//  m_      | out | tdata[5:0] = character, tdata[7:6] = 0, tlast = last character
//
// A value is taken only while idle. Conversion shifts the magnitude through the row of
// BCD cells (one magnitude bit per cycle), then the digit phase shifts the digits out,
// sending a '-' first for a negative value (leading zeros are dropped one per cycle).
// m_tready low stalls only the digit phase.
// Reset clears the control state; digit cells carry no reset.
`default_nettype none
module integer_to_decimal_ascii_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [63:0] value
    input  wire  [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
    output logic        m_tlast
);

    localparam int VB = i2da_pkg::VALUE_BITS;
    localparam int ND = i2da_pkg::NUM_DIGITS;

    i2da_pkg::state_t      state_reg, state_next;
    i2da_pkg::cell_mode_t  cell_mode;

    logic [VB-1:0]               mag_reg, mag_next;
    logic [i2da_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [i2da_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic                        neg_reg, neg_next;
    logic                        started_reg, started_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [5:0]                  char_reg, char_next;
    logic                        last_reg, last_next;

    logic [VB-1:0] in_val;
    logic          in_neg;
    logic          s_fire;
    logic          out_free;
    logic [3:0]    top_digit;

    logic          carry [0:ND];
    logic [3:0]    digit [0:ND-1];

    assign in_val   = s_tdata[VB-1:0];
    assign in_neg   = s_tuser[0] & in_val[VB-1];
    assign s_tready = (state_reg == i2da_pkg::ST_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign top_digit = digit[ND-1];

    assign carry[0] = mag_reg[VB-1];

    genvar g;
    generate
        for (g = 0; g < ND; g++) begin : g_cell
            i2da_cell u_cell (
                .aclk      (aclk),
                .mode      (cell_mode),
                .bit_in    (carry[g]),
                .digit_in  ((g == 0) ? 4'd0 : digit[(g == 0) ? 0 : g-1]),
                .bit_out   (carry[g+1]),
                .digit_out (digit[g])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        cell_mode     = i2da_pkg::CELL_HOLD;
        mag_next      = mag_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        started_next  = started_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        char_next     = char_reg;
        last_next     = last_reg;

        unique case (state_reg)
            i2da_pkg::ST_IDLE: begin
                if (s_fire) begin
                    cell_mode    = i2da_pkg::CELL_CLEAR;
                    mag_next     = in_neg ? (~in_val + {{(VB-1){1'b0}}, 1'b1}) : in_val;
                    neg_next     = in_neg;
                    cnt_next     = i2da_pkg::CNT_W'(VB - 1);
                    rem_next     = i2da_pkg::REM_W'(ND);
                    started_next = 1'b0;
                    state_next   = i2da_pkg::ST_CONV;
                end
            end
            i2da_pkg::ST_CONV: begin
                cell_mode = i2da_pkg::CELL_DABBLE;
                mag_next  = {mag_reg[VB-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = i2da_pkg::ST_EMIT;
                end
            end
            i2da_pkg::ST_EMIT: begin
                if (neg_reg) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        char_next     = i2da_pkg::CHAR_MINUS;
                        last_next     = 1'b0;
                        neg_next      = 1'b0;
                    end
                end else if (top_digit == 4'd0 && !started_reg &&
                             rem_reg != i2da_pkg::REM_W'(1)) begin
                    // leading zero: drop it
                    cell_mode = i2da_pkg::CELL_SHIFT;
                    rem_next  = rem_reg - 1'b1;
                end else if (out_free) begin
                    cell_mode     = i2da_pkg::CELL_SHIFT;
                    rem_next      = rem_reg - 1'b1;
                    started_next  = 1'b1;
                    m_tvalid_next = 1'b1;
                    char_next     = i2da_pkg::CHAR_ZERO + {2'b00, top_digit};
                    last_next     = (rem_reg == i2da_pkg::REM_W'(1));
                    if (rem_reg == i2da_pkg::REM_W'(1)) begin
                        state_next = i2da_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = i2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= i2da_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            neg_reg      <= 1'b0;
            started_reg  <= 1'b0;
            cnt_reg      <= '0;
            rem_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            neg_reg      <= neg_next;
            started_reg  <= started_next;
            cnt_reg      <= cnt_next;
            rem_reg      <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, char_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTH
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] == i2da_pkg::CHAR_MINUS ||
                      (m_tdata[5:0] >= i2da_pkg::CHAR_ZERO &&
                       m_tdata[5:0] <= i2da_pkg::CHAR_ZERO + 6'd9)))
        else $error("character out of range");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5:0] == i2da_pkg::CHAR_MINUS) |-> !m_tlast)
        else $error("minus sign flagged last");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == i2da_pkg::ST_CONV)
        else $error("accepted value did not start conversion");

    a_emit_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == i2da_pkg::ST_EMIT |-> rem_reg != '0)
        else $error("digit phase ran past the last digit");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for integer_to_decimal_ascii_core: stream stimulus and a text predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int TAIL_CYCLES    = 150;

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } text_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [63:0] value
    logic [0:0]  s_tuser  = '0;   // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [5:0] character, [7:6] zero
    logic        m_tlast;

    text_beat_t  expected_chars[$];
    text_beat_t  oldest_char;
    int          mismatches     = 0;
    int          values_sent    = 0;
    int          negatives_sent = 0;
    int          chars_checked  = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          hold_tag       = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;

    integer_to_decimal_ascii_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decimal text of one value, sign first, pushed as expected character beats.
    function automatic void predict_decimal_text(input logic kind, input logic [63:0] raw);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [3:0]  digits[20];
        int          nd;
        logic        negative;
        text_beat_t  beat;
        mask     = {64{1'b1}} >> (64 - i2da_pkg::VALUE_BITS);
        mag      = raw & mask;
        negative = kind && mag[i2da_pkg::VALUE_BITS-1];
        if (negative) begin
            mag = (~mag + 64'd1) & mask;   // most negative value stays exact as unsigned
        end
        nd = 0;
        do begin
            digits[nd] = 4'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
        end while (mag != 0);
        if (negative) begin
            beat.ch   = i2da_pkg::CHAR_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            beat.ch   = i2da_pkg::CHAR_ZERO + 6'(digits[i]);
            beat.last = (i == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // Mix of full-width, short, power-of-ten, sign-boundary and small negative values.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int          sel;
        v   = {$urandom, $urandom};
        sel = $urandom_range(9);
        case (sel) inside
            [4:6]: begin
                v = v >> (64 - $urandom_range(1, 64));
            end
            7: begin
                p = 64'd1;
                repeat ($urandom_range(19)) p = p * 64'd10;
                v = p + 64'($urandom_range(2)) - 64'd1;
            end
            8: begin
                if ($urandom_range(1) == 1)
                    v = {1'b1, 63'd0} + 64'($urandom_range(15));
                else
                    v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(15));
            end
            9: begin
                v = -64'($urandom_range(1000));
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Result side: receiver stalls, plus a long hold-off when hold_tag moves.
    always @(posedge aclk) begin
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                report_mismatch("beat with nothing expected", m_tdata, 8'd0);
            end else begin
                oldest_char = expected_chars.pop_front();
                if (m_tdata !== {2'b00, oldest_char.ch})
                    report_mismatch("character", m_tdata, {2'b00, oldest_char.ch});
                if (m_tlast !== oldest_char.last)
                    report_mismatch("last flag", 8'(m_tlast), 8'(oldest_char.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL integer_to_decimal_ascii_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one value, holds it until taken, then maybe idles before the next one.
    task automatic send_value(input logic kind, input logic [63:0] raw);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        predict_decimal_text(kind, raw);
        values_sent++;
        if (kind && raw[i2da_pkg::VALUE_BITS-1])
            negatives_sent++;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_drain(input int tail);
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic run_random_values(input int count);
        repeat (count) send_value(1'($urandom_range(1)), random_value());
        wait_for_drain(20);
    endtask

    task automatic test_directed_values();
        set_idling(0, 0);
        send_value(1'b0, 64'd0);
        send_value(1'b1, 64'd0);
        send_value(1'b0, 64'd1);
        send_value(1'b0, 64'd9);
        send_value(1'b0, 64'd10);
        send_value(1'b0, 64'd99);
        send_value(1'b0, 64'd100);
        send_value(1'b0, 64'h51EB_851F);
        send_value(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);   // -1
        send_value(1'b0, 64'h8000_0000_0000_0000);
        send_value(1'b1, 64'h8000_0000_0000_0000);   // most negative
        send_value(1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_value(1'b1, 64'h8000_0000_0000_0001);
        send_value(1'b0, 64'd10000000000000000000);
        send_value(1'b0, 64'd9999999999999999999);
        send_value(1'b1, -64'd10);
        send_value(1'b1, 64'd5);
        send_value(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_value(1'b0, 64'h5555_5555_5555_5555);
        wait_for_drain(20);
    endtask

    task automatic test_random_no_idling();
        set_idling(0, 0);
        run_random_values(80);
    endtask

    task automatic test_random_sender_gaps();
        set_idling(84, 0);
        run_random_values(80);
    endtask

    task automatic test_random_receiver_stalls();
        set_idling(0, 84);
        run_random_values(80);
    endtask

    task automatic test_random_both_idling();
        set_idling(12, 12);
        run_random_values(95);
    endtask

    // Result side held off while values keep coming: the input must stall.
    task automatic test_output_hold_off();
        set_idling(0, 0);
        hold_tag <= hold_tag + 1;
        repeat (10) send_value(1'($urandom_range(1)), random_value());
        wait_for_drain(20);
    endtask

    // Each value is sent only once all text from the previous one has arrived.
    task automatic test_pause_until_drained();
        set_idling(0, 30);
        repeat (12) begin
            send_value(1'($urandom_range(1)), random_value());
            wait_for_drain(0);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_values();
        test_random_no_idling();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idling();
        test_output_hold_off();
        test_pause_until_drained();
        wait_for_drain(TAIL_CYCLES);
        $display("converted %0d values (%0d signed negative), %0d characters checked",
                 values_sent, negatives_sent, chars_checked);
        $display("covered idle/stall mixes, a long output hold-off and drained hand-offs");
        if (mismatches == 0) begin
            $display("PASS integer_to_decimal_ascii_core");
        end else begin
            $display("FAIL integer_to_decimal_ascii_core");
        end
        $finish;
    end

endmodule
